>>> hw/rtl/thp_sensor_compensation_top_assert.svh
// Assertion macros shared by the compensation block checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef THP_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define THP_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication, gated off while reset is active
`define THP_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thp check failed");

// next-cycle implication, no reset gating
`define THP_AST_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("thp check failed");

`endif

>>> hw/rtl/thp_pkg.sv
// Shared types and constants for the sensor compensation block.
// No dependencies; used by the top level, the divider and the checker.
`timescale 1ns / 1ps

package thp_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } t_in;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [20:0]        pressure_tenth_hpa;
        logic               pressure_invalid;
        logic [16:0]        humidity_q22_10;
    } t_res;

    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W   = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIXED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_B   = 3'd4;

    // pipeline stages from accept to result strobe: 4 temp + 4 pressure prep + divider + 5 post
    localparam int LATENCY = 4 + 4 + (DIV_W + 2) + 5;

endpackage

>>> hw/rtl/thp_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on thp_pkg; carries a side word alongside each beat.
`timescale 1ns / 1ps

module thp_div #(
    parameter int SIDE_W = 97
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [thp_pkg::DIV_W-1:0] i_num,
    input  logic [thp_pkg::DIV_W-1:0] i_den,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_vld,
    output logic [thp_pkg::DIV_W-1:0] o_quo,
    output logic [SIDE_W-1:0]         o_side
);

    localparam int W = thp_pkg::DIV_W;

    logic              r_v   [0:W];
    logic [W-1:0]      r_rem [0:W];
    logic [W-1:0]      r_q   [0:W];
    logic [W-1:0]      r_d   [0:W];
    logic              r_ng  [0:W];
    logic [SIDE_W-1:0] r_sd  [0:W];

    logic              r_ov;
    logic [W-1:0]      r_oq;
    logic [SIDE_W-1:0] r_os;

    // entry: magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
        end
        r_rem[0] <= '0;
        r_q[0]   <= i_num[W-1] ? ({W{1'b0}} - i_num) : i_num;
        r_d[0]   <= i_den[W-1] ? ({W{1'b0}} - i_den) : i_den;
        r_ng[0]  <= i_num[W-1] ^ i_den[W-1];
        r_sd[0]  <= i_side;
    end

    // restoring stages; r_q shifts dividend bits out and quotient bits in
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0]   sh;
        logic [W+1:0] diff;
        logic         ge;

        assign sh   = {r_rem[k], r_q[k][W-1]};
        assign diff = {1'b0, sh} - {2'b0, r_d[k]};
        assign ge   = ~diff[W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_rem[k+1] <= ge ? diff[W-1:0] : sh[W-1:0];
            r_q[k+1]   <= {r_q[k][W-2:0], ge};
            r_d[k+1]   <= r_d[k];
            r_ng[k+1]  <= r_ng[k];
            r_sd[k+1]  <= r_sd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[W];
        end
        r_oq <= r_ng[W] ? ({W{1'b0}} - r_q[W]) : r_q[W];
        r_os <= r_sd[W];
    end

    assign o_vld  = r_ov;
    assign o_quo  = r_oq;
    assign o_side = r_os;

endmodule

>>> hw/rtl/thp_sensor_compensation_top.sv
// Top level of the temperature / pressure / humidity compensation pipeline.
// Depends on thp_pkg and thp_div.
`timescale 1ns / 1ps

//  channel   dir  handshake                    payload
//  command   in   start, busy                  i_in  (thp_pkg::t_in)
//  result    out  o_done, one-cycle strobe     o_res (thp_pkg::t_res)
//  config    in   i_cfg_we, i_cfg_idx          i_cfg_data
//
// One beat enters per cycle while busy is low; results come out in order, marked by o_done.
// The path runs through eight setup stages, the 66-register divider in the pressure path
// (entry, 64 restoring stages, output) and five post-divide stages. busy is high only during
// reset and the cycle that follows. Results cannot be held off, so nothing ever stalls.

module thp_sensor_compensation_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  thp_pkg::t_in                   i_in,
    output logic                           o_done,
    output thp_pkg::t_res                  o_res,
    input  logic                           i_cfg_we,
    input  logic [thp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [thp_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int SIDE_W = 97;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        asr32 = $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        asr64 = $signed(x) >>> s;
    endfunction

    // 64-bit wrapping product with a signed 16-bit factor, two narrow multiplies
    function automatic logic [63:0] mul64_s16(input logic [63:0] a, input logic [15:0] b);
        logic signed [48:0] lo;
        logic [31:0]        hi;
        lo = $signed({1'b0, a[31:0]}) * $signed(b);
        hi = a[63:32] * {{16{b[15]}}, b};
        mul64_s16 = {{15{lo[48]}}, lo} + {hi, 32'b0};
    endfunction

    function automatic logic [63:0] mul64_u16(input logic [63:0] a, input logic [15:0] b);
        logic [47:0] lo;
        logic [31:0] hi;
        lo = {16'b0, a[31:0]} * {32'b0, b};
        hi = a[63:32] * {16'b0, b};
        mul64_u16 = {16'b0, lo} + {hi, 32'b0};
    endfunction

    // ---------------- configuration ----------------
    logic [47:0] r_cfg_temp;
    logic [63:0] r_cfg_pa;
    logic [63:0] r_cfg_pb;
    logic [47:0] r_cfg_mx;
    logic [31:0] r_cfg_hb;
    logic        r_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_temp <= '0;
            r_cfg_pa   <= '0;
            r_cfg_pb   <= '0;
            r_cfg_mx   <= '0;
            r_cfg_hb   <= '0;
            r_rdy      <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    thp_pkg::REG_TEMP:    r_cfg_temp <= i_cfg_data[47:0];
                    thp_pkg::REG_PRESS_A: r_cfg_pa   <= i_cfg_data;
                    thp_pkg::REG_PRESS_B: r_cfg_pb   <= i_cfg_data;
                    thp_pkg::REG_MIXED:   r_cfg_mx   <= i_cfg_data[47:0];
                    thp_pkg::REG_HUM_B:   r_cfg_hb   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = ~r_rdy;

    logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
    logic [7:0]  h1, h3, h6;
    logic [11:0] h4, h5;

    assign t1 = r_cfg_temp[15:0];
    assign t2 = r_cfg_temp[31:16];
    assign t3 = r_cfg_temp[47:32];
    assign p1 = r_cfg_pa[15:0];
    assign p2 = r_cfg_pa[31:16];
    assign p3 = r_cfg_pa[47:32];
    assign p4 = r_cfg_pa[63:48];
    assign p5 = r_cfg_pb[15:0];
    assign p6 = r_cfg_pb[31:16];
    assign p7 = r_cfg_pb[47:32];
    assign p8 = r_cfg_pb[63:48];
    assign p9 = r_cfg_mx[15:0];
    assign h1 = r_cfg_mx[23:16];
    assign h2 = r_cfg_mx[39:24];
    assign h3 = r_cfg_mx[47:40];
    assign h4 = r_cfg_hb[11:0];
    assign h5 = r_cfg_hb[23:12];
    assign h6 = r_cfg_hb[31:24];

    // ---------------- temperature stages ----------------
    logic        accept;
    logic [31:0] n_t1_ta, n_t1_tb2, tb;
    logic [31:0] n_t2_ta, n_t2_tb, n_tfine, n_t4_temp, t5;
    logic [33:0] n_t4_x1;

    logic        r_t1_v, r_t2_v, r_t3_v, r_t4_v;
    logic [31:0] r_t1_ta, r_t1_tb2, r_t2_ta, r_t2_tb, r_tfine, r_t4_temp, r_t4_hv;
    logic [33:0] r_t4_x1;
    logic [19:0] r_t1_adcp, r_t2_adcp, r_t3_adcp, r_t4_adcp;
    logic [15:0] r_t1_adch, r_t2_adch, r_t3_adch, r_t4_adch;

    assign accept = start & r_rdy;

    always_comb begin
        n_t1_ta  = ({15'b0, i_in.raw_temperature[19:3]} - {15'b0, t1, 1'b0})
                   * {{16{t2[15]}}, t2};
        tb       = {16'b0, i_in.raw_temperature[19:4]} - {16'b0, t1};
        n_t1_tb2 = tb * tb;
        n_t2_ta  = asr32(r_t1_ta, 11);
        n_t2_tb  = asr32(r_t1_tb2, 12) * {{16{t3[15]}}, t3};
        n_tfine  = r_t2_ta + asr32(r_t2_tb, 14);
        t5        = r_tfine * 32'd5 + 32'd128;
        n_t4_temp = asr32(t5, 8);
        n_t4_x1   = {{2{r_tfine[31]}}, r_tfine} - 34'd128000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else begin
            r_t1_v <= accept;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
        end
        r_t1_ta   <= n_t1_ta;
        r_t1_tb2  <= n_t1_tb2;
        r_t1_adcp <= i_in.raw_pressure;
        r_t1_adch <= i_in.raw_humidity;
        r_t2_ta   <= n_t2_ta;
        r_t2_tb   <= n_t2_tb;
        r_t2_adcp <= r_t1_adcp;
        r_t2_adch <= r_t1_adch;
        r_tfine   <= n_tfine;
        r_t3_adcp <= r_t2_adcp;
        r_t3_adch <= r_t2_adch;
        r_t4_temp <= n_t4_temp;
        r_t4_x1   <= n_t4_x1;
        r_t4_hv   <= r_tfine - 32'd76800;
        r_t4_adcp <= r_t3_adcp;
        r_t4_adch <= r_t3_adch;
    end

    // ---------------- pressure setup and humidity front, in parallel ----------------
    logic signed [67:0] sq_full;
    logic signed [49:0] n_x1p5, n_x1p2;
    logic [63:0] n_p2_x2, n_p2_sq3, n_p3_x1, n_p3_num, n_p4_den, n_p4_num;
    logic [20:0] pd;
    logic [31:0] n_h1_h5v, n_h1_vh6, n_h1_vh3, hsum, n_h2_a, n_h2_b, n_h2_e1;
    logic [31:0] be, n_h3_e2, eh, n_h4_e3;

    logic        r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [63:0] r_p1_sq, r_p2_x2, r_p2_sq3, r_p3_x1, r_p3_num, r_p4_den, r_p4_num;
    logic [49:0] r_p1_x1p5, r_p1_x1p2, r_p2_x1p2;
    logic [19:0] r_p1_adcp, r_p2_adcp;
    logic [31:0] r_p1_temp, r_p2_temp, r_p3_temp, r_p4_temp;
    logic [31:0] r_h1_h5v, r_h1_vh6, r_h1_vh3;
    logic [15:0] r_h1_adch;
    logic [31:0] r_h2_a, r_h2_b, r_h2_e1, r_h3_a, r_h3_e2, r_h4_a, r_h4_e3;
    logic        r_p4_inv;

    always_comb begin
        sq_full  = $signed(r_t4_x1) * $signed(r_t4_x1);
        n_x1p5   = $signed(r_t4_x1) * $signed(p5);
        n_x1p2   = $signed(r_t4_x1) * $signed(p2);
        n_p2_x2  = mul64_s16(r_p1_sq, p6) + ({{14{r_p1_x1p5[49]}}, r_p1_x1p5} << 17)
                   + ({{48{p4[15]}}, p4} << 35);
        n_p2_sq3 = mul64_s16(r_p1_sq, p3);
        n_p3_x1  = asr64(r_p2_sq3, 8) + ({{14{r_p2_x1p2[49]}}, r_p2_x1p2} << 12)
                   + 64'h0000_8000_0000_0000;
        pd       = 21'd1048576 - {1'b0, r_p2_adcp};
        n_p3_num = ({43'b0, pd} << 31) - r_p2_x2;
        n_p4_den = asr64(mul64_u16(r_p3_x1, p1), 33);
        n_p4_num = mul64_u16(r_p3_num, 16'd3125);

        n_h1_h5v = r_t4_hv * {{20{h5[11]}}, h5};
        n_h1_vh6 = r_t4_hv * {{24{h6[7]}}, h6};
        n_h1_vh3 = r_t4_hv * {24'b0, h3};
        hsum     = {2'b0, r_h1_adch, 14'b0} - {h4, 20'b0} - r_h1_h5v + 32'd16384;
        n_h2_a   = asr32(hsum, 15);
        n_h2_b   = asr32(r_h1_vh6, 10);
        n_h2_e1  = asr32(r_h1_vh3, 11) + 32'd32768;
        be       = r_h2_b * r_h2_e1;
        n_h3_e2  = asr32(be, 10) + 32'd2097152;
        eh       = r_h3_e2 * {{16{h2[15]}}, h2} + 32'd8192;
        n_h4_e3  = asr32(eh, 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= r_t4_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
        r_p1_sq   <= sq_full[63:0];
        r_p1_x1p5 <= n_x1p5;
        r_p1_x1p2 <= n_x1p2;
        r_p1_adcp <= r_t4_adcp;
        r_p1_temp <= r_t4_temp;
        r_p2_x2   <= n_p2_x2;
        r_p2_sq3  <= n_p2_sq3;
        r_p2_x1p2 <= r_p1_x1p2;
        r_p2_adcp <= r_p1_adcp;
        r_p2_temp <= r_p1_temp;
        r_p3_x1   <= n_p3_x1;
        r_p3_num  <= n_p3_num;
        r_p3_temp <= r_p2_temp;
        r_p4_den  <= n_p4_den;
        r_p4_num  <= n_p4_num;
        r_p4_inv  <= (n_p4_den == 64'd0);
        r_p4_temp <= r_p3_temp;

        r_h1_h5v  <= n_h1_h5v;
        r_h1_vh6  <= n_h1_vh6;
        r_h1_vh3  <= n_h1_vh3;
        r_h1_adch <= r_t4_adch;
        r_h2_a    <= n_h2_a;
        r_h2_b    <= n_h2_b;
        r_h2_e1   <= n_h2_e1;
        r_h3_a    <= r_h2_a;
        r_h3_e2   <= n_h3_e2;
        r_h4_a    <= r_h3_a;
        r_h4_e3   <= n_h4_e3;
    end

    // ---------------- divider ----------------
    logic              div_vld;
    logic [63:0]       div_quo;
    logic [SIDE_W-1:0] div_side;

    thp_div #(
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p4_v),
        .i_num   (r_p4_num),
        .i_den   (r_p4_den),
        .i_side  ({r_p4_temp, r_h4_a, r_h4_e3, r_p4_inv}),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------- post-divide pressure and humidity tail ----------------
    logic [63:0] q13, n_q1_a9, n_q1_y2r, n_q2_ll, n_q3_y1, psum, n_q4_pf;
    logic [31:0] n_q2_cross, n_q1_v2, n_q2_f, n_q2_ff, fh, n_q3_g, hv3, hclamp;
    logic [45:0] tprod;

    logic        r_q1_v, r_q2_v, r_q3_v, r_q4_v, r_done;
    logic [63:0] r_q1_p, r_q1_q13, r_q1_a9, r_q1_y2r;
    logic [63:0] r_q2_p, r_q2_ll, r_q2_y2, r_q3_p, r_q3_y1, r_q3_y2;
    logic [31:0] r_q2_cross;
    logic [31:0] r_q1_temp, r_q2_temp, r_q3_temp, r_q4_temp;
    logic        r_q1_inv, r_q2_inv, r_q3_inv, r_q4_inv;
    logic [31:0] r_q1_v2, r_q2_v2, r_q2_ff, r_q3_v2, r_q3_g, r_q4_pq;
    logic [16:0] r_q4_hum;
    thp_pkg::t_res r_res;

    always_comb begin
        q13        = asr64(div_quo, 13);
        n_q1_a9    = mul64_s16(q13, p9);
        n_q1_y2r   = mul64_s16(div_quo, p8);
        n_q1_v2    = div_side[64:33] * div_side[32:1];
        n_q2_ll    = {32'b0, r_q1_a9[31:0]} * {32'b0, r_q1_q13[31:0]};
        n_q2_cross = r_q1_a9[31:0] * r_q1_q13[63:32] + r_q1_a9[63:32] * r_q1_q13[31:0];
        n_q2_f     = asr32(r_q1_v2, 15);
        n_q2_ff    = n_q2_f * n_q2_f;
        n_q3_y1    = asr64(r_q2_ll + {r_q2_cross, 32'b0}, 25);
        fh         = asr32(r_q2_ff, 7) * {24'b0, h1};
        n_q3_g     = asr32(fh, 4);
        psum       = r_q3_p + r_q3_y1 + r_q3_y2;
        n_q4_pf    = asr64(psum, 8) + ({{48{p7[15]}}, p7} << 4);
        hv3        = r_q3_v2 - r_q3_g;
        // humidity clamp to 0..100 %RH before dropping 12 fraction bits
        if (hv3[31]) begin
            hclamp = 32'd0;
        end else if (hv3 > 32'd419430400) begin
            hclamp = 32'd419430400;
        end else begin
            hclamp = hv3;
        end
        // divide by 2560: drop 9 bits, then reciprocal of 5
        tprod = {23'b0, r_q4_pq[31:9]} * 46'd6710887;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
            r_q2_v <= 1'b0;
            r_q3_v <= 1'b0;
            r_q4_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_q1_v <= div_vld;
            r_q2_v <= r_q1_v;
            r_q3_v <= r_q2_v;
            r_q4_v <= r_q3_v;
            r_done <= r_q4_v;
        end
        r_q1_p     <= div_quo;
        r_q1_q13   <= q13;
        r_q1_a9    <= n_q1_a9;
        r_q1_y2r   <= n_q1_y2r;
        r_q1_temp  <= div_side[96:65];
        r_q1_inv   <= div_side[0];
        r_q1_v2    <= n_q1_v2;

        r_q2_p     <= r_q1_p;
        r_q2_ll    <= n_q2_ll;
        r_q2_cross <= n_q2_cross;
        r_q2_y2    <= asr64(r_q1_y2r, 19);
        r_q2_temp  <= r_q1_temp;
        r_q2_inv   <= r_q1_inv;
        r_q2_v2    <= r_q1_v2;
        r_q2_ff    <= n_q2_ff;

        r_q3_p     <= r_q2_p;
        r_q3_y1    <= n_q3_y1;
        r_q3_y2    <= r_q2_y2;
        r_q3_temp  <= r_q2_temp;
        r_q3_inv   <= r_q2_inv;
        r_q3_v2    <= r_q2_v2;
        r_q3_g     <= n_q3_g;

        r_q4_pq    <= r_q3_inv ? 32'd0 : n_q4_pf[31:0];
        r_q4_hum   <= hclamp[28:12];
        r_q4_temp  <= r_q3_temp;
        r_q4_inv   <= r_q3_inv;

        r_res.temperature_centi  <= r_q4_temp;
        r_res.pressure_q24_8     <= r_q4_pq;
        r_res.pressure_tenth_hpa <= tprod[45:25];
        r_res.pressure_invalid   <= r_q4_inv;
        r_res.humidity_q22_10    <= r_q4_hum;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> hw/rtl/thp_chk.sv
// Port-level checker for the compensation top level, bound below.
// Depends on thp_pkg and thp_sensor_compensation_top_assert.svh.
`timescale 1ns / 1ps
`include "thp_sensor_compensation_top_assert.svh"

module thp_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input thp_pkg::t_res o_res
);

    // every result beat traces back to an accepted command beat
    `THP_AST_IMP(a_done_has_cmd, i_clk, i_rst_n, o_done, $past(start && !busy, thp_pkg::LATENCY))
    `THP_AST_IMP(a_inv_zero, i_clk, i_rst_n, o_done && o_res.pressure_invalid, o_res.pressure_q24_8 == 32'd0 && o_res.pressure_tenth_hpa == 21'd0)
    `THP_AST_IMP(a_hum_clamp, i_clk, i_rst_n, o_done, o_res.humidity_q22_10 <= 17'd102400)
    `THP_AST_NXT(a_rst_quiet, i_clk, !i_rst_n, !o_done)

endmodule

bind thp_sensor_compensation_top thp_chk u_thp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);

>>> bench/testbench.sv
// Self-checking bench for thp_sensor_compensation_top: directed table, then random beats.
// Depends on thp_pkg and the compensation RTL; results checked against an in-bench predictor.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        thp_pkg::t_in  beat;
        bit            typed;  // expectation written out below rather than predicted
        thp_pkg::t_res want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    thp_pkg::t_in                  i_in = '0;
    logic                          o_done;
    thp_pkg::t_res                 o_res;
    logic                          i_cfg_we = 1'b0;
    logic [thp_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [thp_pkg::CFG_W-1:0]     i_cfg_data = '0;

    bit [63:0]     coef_regs [5];
    thp_pkg::t_res pending_results [$];
    int            mismatches = 0;
    int            stray_results = 0;

    thp_sensor_compensation_top dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit [31:0] asr32(bit [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic bit [63:0] asr64(bit [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    // truncating signed divide on magnitudes, wraps like the hardware
    function automatic bit [63:0] div_trunc(bit [63:0] n, bit [63:0] d);
        bit [63:0] an, ad, q;
        an = n[63] ? -n : n;
        ad = d[63] ? -d : d;
        q = an / ad;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    function automatic thp_pkg::t_res compensate(thp_pkg::t_in x);
        bit [31:0] adc_t, adc_h, t1, t2, t3, a, b, tfine, v, e, f;
        bit [31:0] h1, h2, h3, h4, h5, h6, hs;
        bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, p, q13, y1, y2;
        thp_pkg::t_res r;
        adc_t = x.raw_temperature;
        adc_h = x.raw_humidity;
        t1 = coef_regs[thp_pkg::REG_TEMP][15:0];
        t2 = $signed(coef_regs[thp_pkg::REG_TEMP][31:16]);
        t3 = $signed(coef_regs[thp_pkg::REG_TEMP][47:32]);
        p1 = coef_regs[thp_pkg::REG_PRESS_A][15:0];
        p2 = $signed(coef_regs[thp_pkg::REG_PRESS_A][31:16]);
        p3 = $signed(coef_regs[thp_pkg::REG_PRESS_A][47:32]);
        p4 = $signed(coef_regs[thp_pkg::REG_PRESS_A][63:48]);
        p5 = $signed(coef_regs[thp_pkg::REG_PRESS_B][15:0]);
        p6 = $signed(coef_regs[thp_pkg::REG_PRESS_B][31:16]);
        p7 = $signed(coef_regs[thp_pkg::REG_PRESS_B][47:32]);
        p8 = $signed(coef_regs[thp_pkg::REG_PRESS_B][63:48]);
        p9 = $signed(coef_regs[thp_pkg::REG_MIXED][15:0]);
        h1 = coef_regs[thp_pkg::REG_MIXED][23:16];
        h2 = $signed(coef_regs[thp_pkg::REG_MIXED][39:24]);
        h3 = coef_regs[thp_pkg::REG_MIXED][47:40];
        h4 = $signed(coef_regs[thp_pkg::REG_HUM_B][11:0]);
        h5 = $signed(coef_regs[thp_pkg::REG_HUM_B][23:12]);
        h6 = $signed(coef_regs[thp_pkg::REG_HUM_B][31:24]);
        r = '0;

        a = asr32(((adc_t >> 3) - (t1 << 1)) * t2, 11);
        b = (adc_t >> 4) - t1;
        b = asr32(asr32(b * b, 12) * t3, 14);
        tfine = a + b;
        r.temperature_centi = asr32(tfine * 32'd5 + 32'd128, 8);

        x1 = {{32{tfine[31]}}, tfine} - 64'd128000;
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) << 17);
        x2 = x2 + (p4 << 35);
        x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
        x1 = asr64(((64'd1 << 47) + x1) * p1, 33);
        if (x1 == 64'd0) begin
            r.pressure_invalid = 1'b1;
        end else begin
            p = 64'd1048576 - 64'(x.raw_pressure);
            p = ((p << 31) - x2) * 64'd3125;
            p = div_trunc(p, x1);
            q13 = asr64(p, 13);
            y1 = asr64(p9 * q13 * q13, 25);
            y2 = asr64(p8 * p, 19);
            p = asr64(p + y1 + y2, 8) + (p7 << 4);
            r.pressure_q24_8 = p[31:0];
            r.pressure_tenth_hpa = 21'(p[31:0] / 32'd2560);
        end

        v = tfine - 32'd76800;
        a = asr32((adc_h << 14) - h4 * 32'd1048576 - h5 * v + 32'd16384, 15);
        b = asr32(v * h6, 10);
        e = asr32(v * h3, 11) + 32'd32768;
        e = asr32(b * e, 10) + 32'd2097152;
        e = asr32(e * h2 + 32'd8192, 14);
        v = a * e;
        f = asr32(v, 15);
        f = asr32(asr32(f * f, 7) * h1, 4);
        v = v - f;
        if (v[31])
            hs = 0;
        else if (v > 32'd419430400)
            hs = 32'd419430400;
        else
            hs = v;
        r.humidity_q22_10 = 17'(hs >> 12);
        return r;
    endfunction

    always @(posedge i_clk) begin
        thp_pkg::t_res want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                stray_results++;
                $display("unexpected result beat %p", o_res);
            end else begin
                want = pending_results.pop_front();
                if (o_res.temperature_centi !== want.temperature_centi
                        || o_res.pressure_q24_8 !== want.pressure_q24_8
                        || o_res.pressure_tenth_hpa !== want.pressure_tenth_hpa
                        || o_res.pressure_invalid !== want.pressure_invalid
                        || o_res.humidity_q22_10 !== want.humidity_q22_10) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, o_res);
                end
            end
        end
    end

    // hold the beat until the edge that takes it; start stays high afterwards
    task automatic send_beat(thp_pkg::t_in x, bit typed = 1'b0, thp_pkg::t_res want = '0);
        start <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(typed ? want : compensate(x));
    endtask

    task automatic maybe_gap(bit allow);
        if (allow && $urandom_range(99) < 8) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one write beat; the enable drops again before the task returns, ahead of the next call
    task automatic write_reg(logic [thp_pkg::CFG_IDX_W-1:0] idx, bit [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            thp_pkg::REG_TEMP:
                coef_regs[thp_pkg::REG_TEMP] = val & 64'hFFFF_FFFF_FFFF;
            thp_pkg::REG_PRESS_A: coef_regs[thp_pkg::REG_PRESS_A] = val;
            thp_pkg::REG_PRESS_B: coef_regs[thp_pkg::REG_PRESS_B] = val;
            thp_pkg::REG_MIXED:
                coef_regs[thp_pkg::REG_MIXED] = val & 64'hFFFF_FFFF_FFFF;
            thp_pkg::REG_HUM_B:
                coef_regs[thp_pkg::REG_HUM_B] = val & 64'hFFFF_FFFF;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // a plausible calibration set; jitter > 0 perturbs t1..t3, p1..p4, h3 and h5 a little
    task automatic load_nominal(int jitter);
        bit [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
        bit [7:0]  h1, h3, h6;
        bit [11:0] h4, h5;
        t1 = 16'd27504 + 16'($urandom_range(2 * jitter) - jitter);
        t2 = 16'd26435 + 16'($urandom_range(2 * jitter) - jitter);
        t3 = -16'sd1000 + 16'($urandom_range(jitter));
        p1 = 16'd36477 + 16'($urandom_range(2 * jitter) - jitter);
        p2 = -16'sd10685 + 16'($urandom_range(jitter));
        p3 = 16'd3024 + 16'($urandom_range(jitter));
        p4 = 16'd2855 + 16'($urandom_range(jitter));
        p5 = 16'd140;
        p6 = -16'sd7;
        p7 = 16'd15500;
        p8 = -16'sd14600;
        p9 = 16'd6000;
        h1 = 8'd75;
        h2 = 16'd362;
        h3 = 8'(jitter ? $urandom_range(30) : 0);
        h4 = 12'd324;
        h5 = 12'(jitter ? $urandom_range(50) : 0);
        h6 = 8'd30;
        write_reg(thp_pkg::REG_TEMP, {16'h0, t3, t2, t1});
        write_reg(thp_pkg::REG_PRESS_A, {p4, p3, p2, p1});
        write_reg(thp_pkg::REG_PRESS_B, {p8, p7, p6, p5});
        write_reg(thp_pkg::REG_MIXED, {16'h0, h3, h2, h1, p9});
        write_reg(thp_pkg::REG_HUM_B, {32'h0, h6, h5, h4});
    endtask

    function automatic thp_pkg::t_in random_beat();
        thp_pkg::t_in x;
        x.raw_temperature = 20'($urandom);
        x.raw_pressure = 20'($urandom);
        x.raw_humidity = 16'($urandom);
        // realistic band most of the time
        if ($urandom_range(3) != 0) begin
            x.raw_temperature = 20'($urandom_range(560000, 440000));
            x.raw_pressure = 20'($urandom_range(450000, 250000));
            x.raw_humidity = 16'($urandom_range(40000, 20000));
        end
        if ($urandom_range(15) == 0) x.raw_temperature = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(15) == 0) x.raw_pressure = $urandom_range(1) ? '1 : '0;
        if ($urandom_range(15) == 0) x.raw_humidity = $urandom_range(1) ? '1 : '0;
        return x;
    endfunction

    initial begin
        t_row rows [$];
        t_row row;
        int   sent;
        int   phase;
        int   k;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero coefficients: temp 0, divisor 0, humidity 0, whatever the raw beat
        row.typed = 1'b1;
        row.want = '0;
        row.want.pressure_invalid = 1'b1;
        row.beat = '0;                         rows.push_back(row);
        row.beat = '1;                         rows.push_back(row);
        row.beat = {20'hFFFFF, 20'h0, 16'h0};  rows.push_back(row);
        row.beat = {20'h0, 20'hFFFFF, 16'hFFFF}; rows.push_back(row);
        row.beat = {20'h80000, 20'h80000, 16'h8000}; rows.push_back(row);
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].typed, rows[i].want);
        drain();

        // nominal calibration: room reading, extremes, humidity at both clamps
        load_nominal(0);
        rows.delete();
        row.typed = 1'b0;
        row.beat = {20'd519888, 20'd415148, 16'd30000}; rows.push_back(row);
        row.beat = '0;                                   rows.push_back(row);
        row.beat = '1;                                   rows.push_back(row);
        row.beat = {20'd519888, 20'h0, 16'h0};           rows.push_back(row);
        row.beat = {20'd519888, 20'hFFFFF, 16'hFFFF};    rows.push_back(row);
        row.beat = {20'h0, 20'd415148, 16'd30000};       rows.push_back(row);
        row.beat = {20'hFFFFF, 20'd415148, 16'd30000};   rows.push_back(row);
        foreach (rows[i]) send_beat(rows[i].beat);
        drain();

        // p1 zero forces the invalid flag with live temperature and humidity
        write_reg(thp_pkg::REG_PRESS_A, coef_regs[thp_pkg::REG_PRESS_A] & ~64'hFFFF);
        send_beat({20'd519888, 20'd415148, 16'd30000});
        send_beat('1);
        drain();

        // all-ones registers, then indexes off the end (ignored)
        for (k = 0; k < 5; k++) write_reg(thp_pkg::CFG_IDX_W'(k), '1);
        send_beat('0);
        send_beat('1);
        send_beat({20'd519888, 20'd415148, 16'd30000});
        drain();
        write_reg(3'd5, 64'($urandom) << 32 | 64'($urandom));
        write_reg(3'd6, '1);
        write_reg(3'd7, '0);
        send_beat({20'd519888, 20'd415148, 16'd30000});
        drain();

        // random part: six calibration settings, ~300 beats each
        sent = 0;
        for (phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0, 2, 4: load_nominal(phase * 40 + 10);
                1: for (k = 0; k < 5; k++)
                    write_reg(thp_pkg::CFG_IDX_W'(k), {32'($urandom), 32'($urandom)});
                3: begin
                    load_nominal(5);
                    if ($urandom_range(1))
                        write_reg(thp_pkg::REG_PRESS_A, 64'h8000_8000_8000_0000);
                    else
                        write_reg(thp_pkg::REG_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
                end
                default: for (k = 0; k < 5; k++) write_reg(thp_pkg::CFG_IDX_W'(k), '0);
            endcase
            repeat (300) begin
                send_beat(random_beat());
                sent++;
                // one long run with no gaps at all
                maybe_gap(sent < 600 || sent > 1100);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (thp_pkg::LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && stray_results == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
